@@ design/diamond_square_heightmap_unit_assert.svh @@
// Assertion macros for the height-map engine.
`ifndef DIAMOND_SQUARE_HEIGHTMAP_UNIT_ASSERT_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DSH_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dsh assertion failed");
`define DSH_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dsh forbidden condition seen");
`else
`define DSH_ASSERT(lbl, prop)
`define DSH_NEVER(lbl, expr)
`endif
`endif

@@ design/dsh_pkg.sv @@
// Shared constants, codes and helpers of the height-map engine.
`default_nettype none
package dsh_pkg;
	localparam int MAX_SIDE_LOG = 6;
	localparam int MAX_BLOCKS   = 4;
	localparam int MAX_SIDE     = 1 << MAX_SIDE_LOG;
	localparam int STORE_DEPTH  = (MAX_SIDE * MAX_BLOCKS + 1) * (MAX_SIDE + 1);
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
	localparam int XY_W         = 9;
	localparam int IDX_W        = 2;
	localparam int DATA_W       = 31;

	localparam logic [15:0] LEHMER_A = 16'd48271;
	localparam logic [30:0] LEHMER_M = 31'h7fffffff;
	localparam logic signed [15:0] HALF_Q12 = 16'sd2048;

	typedef enum logic [1:0] {
		FUNC_GEN  = 2'd0,
		FUNC_NORM = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OUT  = 2'd1,
		ST_FLAT = 2'd2
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SIDE_LOG = 2'd0,
		REG_BLOCKS   = 2'd1,
		REG_WIDE     = 2'd2,
		REG_SEED     = 2'd3
	} reg_idx_t;

	// Displacement scale per pass, round(3 * 2^(-0.7*(s+2)) * 65536).
	function automatic logic [16:0] step_scale(input logic [2:0] s);
		logic [16:0] r;
		case (s)
			3'd0: r = 17'd74500;
			3'd1: r = 17'd45860;
			3'd2: r = 17'd28230;
			3'd3: r = 17'd17378;
			3'd4: r = 17'd10697;
			3'd5: r = 17'd6585;
			3'd6: r = 17'd4054;
			3'd7: r = 17'd2495;
			default: r = 17'd2495;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ design/dsh_if.sv @@
// Handshake channels of the height-map engine: command, result and config write.
`default_nettype none
interface dsh_in_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic [dsh_pkg::XY_W-1:0]     x;
	logic [dsh_pkg::XY_W-1:0]     y;
	modport source (output valid, func, x, y, input ready);
	modport sink   (input valid, func, x, y, output ready);
endinterface

interface dsh_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] height_value;
	logic [1:0]        status;
	modport source (output valid, height_value, status, input ready);
	modport sink   (input valid, height_value, status, output ready);
endinterface

interface dsh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dsh_pkg::IDX_W-1:0]   index;
	logic [dsh_pkg::DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/diamond_square_heightmap_unit.sv @@
// Diamond-square height-map engine: command sequencer around one height memory.
//
// Channels: in_ch takes commands (func, x, y), out_ch returns one item per
// command (height_value, status), cfg writes the four geometry/seed registers
// and is always ready. Commands are taken one at a time; in_ch.ready is high
// while the sequencer is idle.
// Sequencing: a read passes through S_RD and S_RDW into the result register;
// a point outside the map goes straight to S_DONE. Generate writes one block
// corner per cycle, then reads the corners of each diamond point and the two
// ends of each square midpoint before writing it, and spends an extra state on
// each missing midpoint on the right and bottom edges. Normalize sweeps the
// map (N = (W+1)*(H+1) points) once for min/max and once more with a 13-step
// divider per point.
// Reset clears the registers to side log 6, one block, tall layout, seed 1;
// the height memory is not cleared and must be generated before use.
// A stalled receiver holds the result in the output register; a following
// result waits in the sequencer until that register is free.
`default_nettype none
`include "diamond_square_heightmap_unit_assert.svh"
module diamond_square_heightmap_unit (
	input  wire        clk,
	input  wire        arst_n,
	dsh_in_if.sink     in_ch,
	dsh_out_if.source  out_ch,
	dsh_cfg_if.sink    cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_RDW, S_SEED, S_GRD, S_GWAIT, S_GWR, S_GSEL,
		S_N1, S_N1W, S_NCHK, S_N2RD, S_N2LD, S_N2DIV, S_N2WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		M_DIA, M_SQA, M_SQB
	} mode_t;

	localparam int XW = dsh_pkg::XY_W;
	localparam int AW = dsh_pkg::ADDR_W;
	localparam int CW = dsh_pkg::CNT_W;

	state_t state_q;
	mode_t  mode_q;

	logic [2:0]  side_log_q, blk_cnt_q;
	logic        wide_q;
	logic [30:0] gen_q;

	logic [XW-1:0] w_q, h_q, gx_q, gy_q, dim_q;
	logic [2:0]    step_q;
	logic [1:0]    ph_q;
	logic          rv_s1;
	logic signed [17:0] sum_q;
	logic [46:0]   prod_q;
	logic signed [33:0] dmul_q;

	logic [CW-1:0] n_q, nidx_q;
	logic signed [15:0] lo_q, hi_q;
	logic [15:0]   den_q;
	logic [28:0]   rem_q;
	logic [12:0]   quot_q;
	logic [3:0]    bit_q;

	logic signed [15:0] res_h_q, out_h_q;
	logic [1:0]    res_st_q, out_st_q;
	logic          out_vld_q;

	logic [15:0]   mem [dsh_pkg::STORE_DEPTH];
	logic signed [15:0] rd_s1;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;

	// Geometry from the current registers.
	logic [2:0]    lg_c, cnt_c;
	logic [XW-1:0] side_c, span_c, w_c, h_c;
	logic [CW-1:0] n_c;

	always_comb begin
		if (side_log_q == 3'd0)
			lg_c = 3'd1;
		else if (side_log_q > 3'(dsh_pkg::MAX_SIDE_LOG))
			lg_c = 3'(dsh_pkg::MAX_SIDE_LOG);
		else
			lg_c = side_log_q;
		if (blk_cnt_q == 3'd0)
			cnt_c = 3'd1;
		else if (blk_cnt_q > 3'(dsh_pkg::MAX_BLOCKS))
			cnt_c = 3'(dsh_pkg::MAX_BLOCKS);
		else
			cnt_c = blk_cnt_q;
		side_c = XW'(1) << lg_c;
		span_c = XW'(cnt_c) << lg_c;
		w_c = wide_q ? span_c : side_c;
		h_c = wide_q ? side_c : span_c;
		n_c = CW'((2*XW)'(w_c + 1'b1) * (2*XW)'(h_c + 1'b1));
	end

	// Point selection for the shared address multiplier.
	logic [XW-1:0] hd, rx, ry, wx, wy, ax, ay, stride;
	logic [2*XW-1:0] idx_full;

	always_comb begin
		hd = dim_q >> 1;
		rx = gx_q;
		ry = gy_q;
		case (mode_q)
			M_DIA: begin
				if (ph_q == 2'd1 || ph_q == 2'd2) rx = gx_q + dim_q;
				if (ph_q == 2'd2 || ph_q == 2'd3) ry = gy_q + dim_q;
			end
			M_SQA: if (ph_q == 2'd1) rx = gx_q + dim_q;
			M_SQB: if (ph_q == 2'd1) ry = gy_q + dim_q;
			default: ;
		endcase
		wx = gx_q;
		wy = gy_q;
		if (state_q == S_GWR) begin
			case (mode_q)
				M_DIA: begin
					wx = gx_q + hd;
					wy = gy_q + hd;
				end
				M_SQA: wx = gx_q + hd;
				M_SQB: wy = gy_q + hd;
				default: ;
			endcase
		end
		ax = (state_q == S_GWR || state_q == S_SEED) ? wx : rx;
		ay = (state_q == S_GWR || state_q == S_SEED) ? wy : ry;
		stride = w_q + 1'b1;
		idx_full = ay * stride + (2*XW)'(ax);
	end

	// Lehmer step reduced modulo 2^31-1.
	logic [31:0] lsum;
	logic [30:0] lnext;
	always_comb begin
		lsum = 32'(prod_q[30:0]) + 32'(prod_q[46:31]);
		if (lsum >= 32'(dsh_pkg::LEHMER_M))
			lsum = lsum - 32'(dsh_pkg::LEHMER_M);
		lnext = lsum[30:0];
		if (lnext == 31'd0)
			lnext = dsh_pkg::LEHMER_M;
	end

	// New height: mean plus displacement, saturated.
	logic signed [18:0] avg_t, sum_rnd;
	logic signed [34:0] disp_t;
	logic signed [19:0] newh;
	logic signed [15:0] sat_h, u_val;
	always_comb begin
		u_val = $signed({~gen_q[30], gen_q[29:15]});
		if (mode_q == M_DIA) begin
			sum_rnd = 19'(sum_q) + 19'sd2;
			avg_t = sum_rnd >>> 2;
		end else begin
			sum_rnd = 19'(sum_q) + 19'sd1;
			avg_t = sum_rnd >>> 1;
		end
		disp_t = (35'(dmul_q) + 35'sd524288) >>> 20;
		newh = 20'(avg_t) + 20'(disp_t);
		if (newh > 20'sd32767)
			sat_h = 16'sd32767;
		else if (newh < -20'sd32768)
			sat_h = -16'sd32768;
		else
			sat_h = newh[15:0];
	end

	// Square-pass position advance and end of a pass.
	logic [XW-1:0] adv_x, adv_y;
	logic          adv_end;
	always_comb begin
		adv_x = gx_q + dim_q;
		adv_y = gy_q;
		adv_end = 1'b0;
		if (gx_q == w_q) begin
			adv_x = '0;
			adv_y = gy_q + dim_q;
			adv_end = (gy_q == h_q);
		end
	end

	logic [28:0] dtrial;
	logic [16:0] ndiff;
	always_comb begin
		dtrial = 29'(den_q) << bit_q;
		ndiff = 17'(rd_s1) - 17'(lo_q);
	end

	always_comb begin
		mem_we = (state_q == S_SEED) || (state_q == S_GWR) || (state_q == S_N2WR);
		mem_wd = 16'(quot_q);
		if (state_q == S_SEED)
			mem_wd = dsh_pkg::HALF_Q12;
		else if (state_q == S_GWR)
			mem_wd = sat_h;
		if (state_q == S_N1 || state_q == S_N2RD || state_q == S_N2WR) begin
			mem_ra = nidx_q[AW-1:0];
			mem_wa = nidx_q[AW-1:0];
		end else begin
			mem_ra = idx_full[AW-1:0];
			mem_wa = idx_full[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[mem_ra];
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_vld_q;
	assign out_ch.height_value = out_h_q;
	assign out_ch.status = out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= M_DIA;
			side_log_q <= 3'(dsh_pkg::MAX_SIDE_LOG);
			blk_cnt_q <= 3'd1;
			wide_q <= 1'b0;
			gen_q <= 31'd1;
			rv_s1 <= 1'b0;
			ph_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && out_ch.ready)
				out_vld_q <= 1'b0;
			if (cfg.valid) begin
				case (dsh_pkg::reg_idx_t'(cfg.index))
					dsh_pkg::REG_SIDE_LOG: side_log_q <= cfg.data[2:0];
					dsh_pkg::REG_BLOCKS:   blk_cnt_q <= cfg.data[2:0];
					dsh_pkg::REG_WIDE:     wide_q <= cfg.data[0];
					dsh_pkg::REG_SEED:     gen_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					rv_s1 <= 1'b0;
					if (in_ch.valid) begin
						w_q <= w_c;
						h_q <= h_c;
						gx_q <= in_ch.x;
						gy_q <= in_ch.y;
						res_h_q <= '0;
						res_st_q <= dsh_pkg::ST_OK;
						case (dsh_pkg::func_t'(in_ch.func))
							dsh_pkg::FUNC_GEN: begin
								gx_q <= '0;
								gy_q <= '0;
								dim_q <= side_c;
								state_q <= S_SEED;
							end
							dsh_pkg::FUNC_NORM: begin
								n_q <= n_c;
								nidx_q <= '0;
								lo_q <= 16'sd32767;
								hi_q <= -16'sd32768;
								state_q <= S_N1;
							end
							dsh_pkg::FUNC_READ: begin
								if (in_ch.x > w_c || in_ch.y > h_c) begin
									res_st_q <= dsh_pkg::ST_OUT;
									state_q <= S_DONE;
								end else begin
									mode_q <= M_DIA;
									ph_q <= '0;
									state_q <= S_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					res_h_q <= rd_s1;
					state_q <= S_DONE;
				end
				S_SEED: begin
					if (gx_q == w_q) begin
						gx_q <= '0;
						if (gy_q == h_q) begin
							gy_q <= '0;
							step_q <= '0;
							mode_q <= M_DIA;
							ph_q <= '0;
							state_q <= S_GRD;
						end else begin
							gy_q <= gy_q + dim_q;
						end
					end else begin
						gx_q <= gx_q + dim_q;
					end
				end
				S_GRD: begin
					rv_s1 <= 1'b1;
					if (ph_q == 2'd0) begin
						prod_q <= 47'(dsh_pkg::LEHMER_A) * 47'(gen_q);
						sum_q <= '0;
					end else if (rv_s1) begin
						sum_q <= sum_q + 18'(rd_s1);
					end
					if (ph_q == 2'd1)
						gen_q <= lnext;
					if ((mode_q == M_DIA && ph_q == 2'd3) ||
					    (mode_q != M_DIA && ph_q == 2'd1))
						state_q <= S_GWAIT;
					ph_q <= ph_q + 2'd1;
				end
				S_GWAIT: begin
					rv_s1 <= 1'b0;
					sum_q <= sum_q + 18'(rd_s1);
					dmul_q <= u_val * $signed({1'b0, dsh_pkg::step_scale(step_q)});
					state_q <= S_GWR;
				end
				S_GWR: begin
					ph_q <= '0;
					case (mode_q)
						M_DIA: begin
							if (gx_q + dim_q == w_q) begin
								gx_q <= '0;
								if (gy_q + dim_q == h_q) begin
									gy_q <= '0;
									mode_q <= M_SQA;
									state_q <= S_GSEL;
								end else begin
									gy_q <= gy_q + dim_q;
									state_q <= S_GRD;
								end
							end else begin
								gx_q <= gx_q + dim_q;
								state_q <= S_GRD;
							end
						end
						M_SQA: begin
							mode_q <= M_SQB;
							state_q <= S_GSEL;
						end
						default: begin
							mode_q <= M_SQA;
							gx_q <= adv_x;
							gy_q <= adv_y;
							state_q <= S_GSEL;
							if (adv_end) begin
								gx_q <= '0;
								gy_q <= '0;
								if (dim_q == XW'(2)) begin
									state_q <= S_DONE;
								end else begin
									dim_q <= hd;
									step_q <= step_q + 3'd1;
									mode_q <= M_DIA;
									state_q <= S_GRD;
								end
							end
						end
					endcase
				end
				S_GSEL: begin
					if (mode_q == M_SQA) begin
						if (gx_q < w_q)
							state_q <= S_GRD;
						else
							mode_q <= M_SQB;
					end else if (gy_q < h_q) begin
						state_q <= S_GRD;
					end else begin
						// Nothing at this lattice point; move on.
						mode_q <= M_SQA;
						gx_q <= adv_x;
						gy_q <= adv_y;
						if (adv_end) begin
							gx_q <= '0;
							gy_q <= '0;
							if (dim_q == XW'(2)) begin
								state_q <= S_DONE;
							end else begin
								dim_q <= hd;
								step_q <= step_q + 3'd1;
								mode_q <= M_DIA;
								state_q <= S_GRD;
							end
						end
					end
				end
				S_N1: begin
					rv_s1 <= 1'b1;
					if (rv_s1) begin
						if (rd_s1 < lo_q) lo_q <= rd_s1;
						if (rd_s1 > hi_q) hi_q <= rd_s1;
					end
					nidx_q <= nidx_q + 1'b1;
					if (nidx_q == n_q - 1'b1)
						state_q <= S_N1W;
				end
				S_N1W: begin
					rv_s1 <= 1'b0;
					if (rd_s1 < lo_q) lo_q <= rd_s1;
					if (rd_s1 > hi_q) hi_q <= rd_s1;
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					nidx_q <= '0;
					den_q <= 16'(17'(hi_q) - 17'(lo_q));
					if (hi_q == lo_q) begin
						res_st_q <= dsh_pkg::ST_FLAT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_N2RD;
					end
				end
				S_N2RD: state_q <= S_N2LD;
				S_N2LD: begin
					rem_q <= 29'({ndiff[15:0], 12'b0}) + 29'(den_q >> 1);
					quot_q <= '0;
					bit_q <= 4'd12;
					state_q <= S_N2DIV;
				end
				S_N2DIV: begin
					if (rem_q >= dtrial) begin
						rem_q <= rem_q - dtrial;
						quot_q[bit_q] <= 1'b1;
					end
					bit_q <= bit_q - 4'd1;
					if (bit_q == 4'd0)
						state_q <= S_N2WR;
				end
				S_N2WR: begin
					if (nidx_q == n_q - 1'b1) begin
						state_q <= S_DONE;
					end else begin
						nidx_q <= nidx_q + 1'b1;
						state_q <= S_N2RD;
					end
				end
				S_DONE: begin
					// Hold until the output register is free.
					if (!out_vld_q || out_ch.ready) begin
						out_vld_q <= 1'b1;
						out_h_q <= res_h_q;
						out_st_q <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DSH_ASSERT(a_wr_in_range, mem_we |-> (32'(mem_wa) < dsh_pkg::STORE_DEPTH))
	`DSH_ASSERT(a_err_zero_h, (out_vld_q && out_st_q != dsh_pkg::ST_OK) |-> (out_h_q == 16'sd0))
	`DSH_ASSERT(a_quot_range, (state_q == S_N2WR) |-> (quot_q <= 13'd4096))
	`DSH_NEVER(a_busy_ready, in_ch.ready && (state_q == S_GRD || state_q == S_N2DIV))
endmodule
`default_nettype wire

@@ bench/tb_diamond_square_heightmap_unit.sv @@
// Self-checking testbench for the diamond-square height-map engine.
`default_nettype none
module tb_diamond_square_heightmap_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 1000000;
	localparam int MODE_FREE = 0, MODE_SEND_IDLE = 1, MODE_RECV_STALL = 2, MODE_BOTH = 3;

	typedef struct {
		logic signed [15:0] height;
		logic [1:0]         status;
	} height_result_t;

	logic clk;
	logic arst_n;

	dsh_in_if  in_ch();
	dsh_out_if out_ch();
	dsh_cfg_if cfg_ch();

	diamond_square_heightmap_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// Model state of the engine
	shortint     height_mem [dsh_pkg::STORE_DEPTH];
	logic [2:0]  side_log_reg;
	logic [2:0]  block_count_reg;
	logic        wide_reg;
	logic [30:0] lehmer_state;
	int unsigned map_w, map_h;

	height_result_t pending_results[$];
	int  error_count;
	int  idle_mode;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned eff_side_log();
		if (side_log_reg < 1) return 1;
		if (side_log_reg > dsh_pkg::MAX_SIDE_LOG) return dsh_pkg::MAX_SIDE_LOG;
		return side_log_reg;
	endfunction

	function automatic int unsigned eff_blocks();
		if (block_count_reg < 1) return 1;
		if (block_count_reg > dsh_pkg::MAX_BLOCKS) return dsh_pkg::MAX_BLOCKS;
		return block_count_reg;
	endfunction

	function automatic void update_geometry();
		int unsigned s;
		s = 1 << eff_side_log();
		if (wide_reg) begin
			map_w = s * eff_blocks();
			map_h = s;
		end else begin
			map_w = s;
			map_h = s * eff_blocks();
		end
	endfunction

	function automatic longint height_at(int unsigned x, int unsigned y);
		int unsigned i;
		if (x > map_w || y > map_h) return 0;
		i = y * (map_w + 1) + x;
		if (i >= dsh_pkg::STORE_DEPTH) return 0;
		return height_mem[i];
	endfunction

	function automatic void store_height(int unsigned x, int unsigned y, longint v);
		int unsigned i;
		if (x > map_w || y > map_h) return;
		i = y * (map_w + 1) + x;
		if (i >= dsh_pkg::STORE_DEPTH) return;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		height_mem[i] = shortint'(v);
	endfunction

	function automatic longint offset_draw(int unsigned pass);
		longint unsigned p;
		longint u;
		longint scale;
		p = (64'd48271 * lehmer_state) % 64'd2147483647;
		if (p == 0) p = 64'd2147483647;
		lehmer_state = p[30:0];
		u = longint'(p >> 15) - 32768;
		scale = longint'(dsh_pkg::step_scale(pass[2:0]));
		return (u * scale + (64'sd1 << 19)) >>> 20;
	endfunction

	function automatic void build_map();
		int unsigned n, side, xb, yb, dim, hd, nx, ny, x, y;
		longint sum;
		n = eff_side_log();
		side = 1 << n;
		xb = map_w / side;
		yb = map_h / side;
		dim = side;
		for (int unsigned i = 0; i <= yb; i++)
			for (int unsigned j = 0; j <= xb; j++)
				store_height(j * side, i * side, dsh_pkg::HALF_Q12);
		for (int unsigned s = 0; s < n; s++) begin
			ny = (1 << s) * yb;
			nx = (1 << s) * xb;
			hd = dim >> 1;
			for (int unsigned i = 0; i < ny; i++)
				for (int unsigned j = 0; j < nx; j++) begin
					x = j * dim;
					y = i * dim;
					sum = height_at(x, y) + height_at(x + dim, y)
						+ height_at(x + dim, y + dim) + height_at(x, y + dim);
					store_height(x + hd, y + hd, ((sum + 2) >>> 2) + offset_draw(s));
				end
			for (int unsigned i = 0; i <= ny; i++)
				for (int unsigned j = 0; j <= nx; j++) begin
					x = j * dim;
					y = i * dim;
					if (j < nx) begin
						sum = height_at(x, y) + height_at(x + dim, y);
						store_height(x + hd, y, ((sum + 1) >>> 1) + offset_draw(s));
					end
					if (i < ny) begin
						sum = height_at(x, y) + height_at(x, y + dim);
						store_height(x, y + hd, ((sum + 1) >>> 1) + offset_draw(s));
					end
				end
			dim = hd;
		end
	endfunction

	// Returns 0 when the map is flat and left untouched.
	function automatic bit rescale_map();
		longint lo, hi, h, den;
		lo = 32767;
		hi = -32768;
		for (int unsigned i = 0; i <= map_h; i++)
			for (int unsigned j = 0; j <= map_w; j++) begin
				h = height_at(j, i);
				if (h < lo) lo = h;
				if (h > hi) hi = h;
			end
		if (hi == lo) return 0;
		den = hi - lo;
		for (int unsigned i = 0; i <= map_h; i++)
			for (int unsigned j = 0; j <= map_w; j++)
				store_height(j, i, ((height_at(j, i) - lo) * 4096 + den / 2) / den);
		return 1;
	endfunction

	function automatic height_result_t predict_command(logic [1:0] f, logic [8:0] x,
			logic [8:0] y);
		height_result_t r;
		r.height = '0;
		r.status = dsh_pkg::ST_OK;
		update_geometry();
		case (f)
			dsh_pkg::FUNC_GEN: build_map();
			dsh_pkg::FUNC_NORM: if (!rescale_map()) r.status = dsh_pkg::ST_FLAT;
			dsh_pkg::FUNC_READ: begin
				if (x > map_w || y > map_h) r.status = dsh_pkg::ST_OUT;
				else r.height = 16'(height_at(x, y));
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic bit send_gap();
		int pct;
		pct = (idle_mode == MODE_SEND_IDLE) ? 53 : (idle_mode == MODE_BOTH) ? 7 : 0;
		return $urandom_range(99) < pct;
	endfunction

	task automatic send_command(logic [1:0] f, logic [8:0] x, logic [8:0] y);
		bit taken;
		if (send_gap()) begin
			in_ch.valid <= 1'b0;
			while (send_gap()) @(posedge clk);
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func  <= f;
		in_ch.x     <= x;
		in_ch.y     <= y;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(predict_command(f, x, y));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(dsh_pkg::reg_idx_t idx, logic [30:0] data);
		bit taken;
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end while (!taken);
		cfg_ch.valid <= 1'b0;
		case (idx)
			dsh_pkg::REG_SIDE_LOG: side_log_reg = data[2:0];
			dsh_pkg::REG_BLOCKS:   block_count_reg = data[2:0];
			dsh_pkg::REG_WIDE:     wide_reg = data[0];
			dsh_pkg::REG_SEED:     lehmer_state = data;
			default: ;
		endcase
	endtask

	task automatic set_geometry(logic [2:0] l, logic [2:0] c, logic w);
		write_register(dsh_pkg::REG_SIDE_LOG, 31'(l));
		write_register(dsh_pkg::REG_BLOCKS, 31'(c));
		write_register(dsh_pkg::REG_WIDE, 31'(w));
	endtask

	// Clamped side and count, seed extremes, the full-size map in both layouts.
	task automatic test_directed();
		idle_mode = MODE_FREE;
		set_geometry(3'd7, 3'd7, 1'b0);
		send_command(dsh_pkg::FUNC_GEN, '0, '0);
		send_command(dsh_pkg::FUNC_READ, 9'd64, 9'd256);
		send_command(dsh_pkg::FUNC_READ, 9'd65, 9'd0);
		send_command(dsh_pkg::FUNC_READ, 9'd0, 9'd257);
		send_command(dsh_pkg::FUNC_READ, 9'd511, 9'd511);
		send_command(dsh_pkg::FUNC_NORM, '0, '0);
		send_command(dsh_pkg::FUNC_READ, 9'd32, 9'd128);
		send_command(FUNC_SPARE, 9'd5, 9'd5);
		write_register(dsh_pkg::REG_WIDE, 31'd1);
		send_command(dsh_pkg::FUNC_READ, 9'd256, 9'd64);
		send_command(dsh_pkg::FUNC_READ, 9'd256, 9'd65);
		send_command(dsh_pkg::FUNC_READ, 9'd257, 9'd0);
		set_geometry(3'd0, 3'd0, 1'b0);
		write_register(dsh_pkg::REG_SEED, 31'd0);
		send_command(dsh_pkg::FUNC_GEN, '0, '0);
		send_command(dsh_pkg::FUNC_READ, 9'd1, 9'd1);
		send_command(dsh_pkg::FUNC_READ, 9'd2, 9'd2);
		send_command(dsh_pkg::FUNC_READ, 9'd3, 9'd0);
		write_register(dsh_pkg::REG_SEED, 31'h7fffffff);
		send_command(dsh_pkg::FUNC_GEN, '0, '0);
		send_command(dsh_pkg::FUNC_NORM, '0, '0);
		send_command(dsh_pkg::FUNC_READ, 9'd0, 9'd1);
		write_register(dsh_pkg::REG_SEED, 31'h7ffffffe);
		send_command(dsh_pkg::FUNC_GEN, '0, '0);
		send_command(dsh_pkg::FUNC_READ, 9'd1, 9'd0);
		drain();
	endtask

	task automatic random_commands(int count);
		int pick;
		logic [8:0] x, y;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			update_geometry();
			if ($urandom_range(9) < 7) begin
				x = 9'($urandom_range(map_w));
				y = 9'($urandom_range(map_h));
			end else begin
				x = 9'($urandom);
				y = 9'($urandom);
			end
			if (pick < 4) send_command(dsh_pkg::FUNC_GEN, x, y);
			else if (pick < 7) send_command(dsh_pkg::FUNC_NORM, x, y);
			else if (pick < 10) send_command(FUNC_SPARE, x, y);
			else send_command(dsh_pkg::FUNC_READ, x, y);
		end
	endtask

	// The whole store has been written by the full-size map, so any geometry reads known data.
	task automatic test_random();
		for (int m = MODE_FREE; m <= MODE_BOTH; m++) begin
			idle_mode = m;
			for (int c = 0; c < 2; c++) begin
				set_geometry(3'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom));
				write_register(dsh_pkg::REG_SEED, 31'($urandom));
				send_command(dsh_pkg::FUNC_GEN, '0, '0);
				random_commands(115);
				drain();
			end
		end
	endtask

	// Receiver side: stall per phase, compare each item at the negedge before its accept edge.
	always @(posedge clk) begin
		int pct;
		pct = (idle_mode == MODE_RECV_STALL) ? 53 : (idle_mode == MODE_BOTH) ? 7 : 0;
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= pct);
	end

	always @(negedge clk) begin
		height_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: height_value %0d status %0d",
					out_ch.height_value, out_ch.status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.height_value !== want.height) begin
					$error("height_value: expected %0d, got %0d", want.height,
						out_ch.height_value);
					error_count++;
				end
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_ch.status);
					error_count++;
				end
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		idle_cycles = 0;
		idle_mode = MODE_FREE;
		foreach (height_mem[i]) height_mem[i] = 0;
		side_log_reg = 3'd6;
		block_count_reg = 3'd1;
		wide_reg = 1'b0;
		lehmer_state = 31'd1;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.func <= dsh_pkg::FUNC_READ;
		in_ch.x <= '0;
		in_ch.y <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= dsh_pkg::REG_SIDE_LOG;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/dsh_pkg.sv
design/dsh_if.sv
design/diamond_square_heightmap_unit.sv
bench/tb_diamond_square_heightmap_unit.sv
